>>> design/ring_entry_store_offset_lookup_core_macros.svh
// Assertion macros shared by the checker of the offset lookup core.
// Each macro samples on clk_i and is held off while rst_ni is low.
`ifndef RING_ENTRY_STORE_OFFSET_LOOKUP_CORE_MACROS_SVH
`define RING_ENTRY_STORE_OFFSET_LOOKUP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RESOL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("offset lookup core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RESOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("offset lookup core: next-cycle check failed");

`endif

>>> design/resol_pkg.sv
package resol_pkg;

  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 16;
  localparam int OFFSET_W = 24;
  localparam int TOTAL_W  = 20;
  localparam int SLOT_OUT_W = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // Lookup token that travels from cell to cell during a find.
  typedef struct packed {
    logic                active;
    logic [OFFSET_W-1:0] rem;
  } tok_t;

  // Per-cell answer; all zero unless the token sits in that cell.
  typedef struct packed {
    logic                hit;
    logic                miss;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] off;
  } res_t;

endpackage

>>> design/ring_entry_store_offset_lookup_core.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | kind, entry_handle, entry_length, byte_offset
// out     | output    | out_valid_o / out_stall_i | found, slot_index, hit_handle,
//         |           |                         | offset_in_entry, evicted, evicted_handle,
//         |           |                         | total_bytes
//
// An add word's result appears in the output register on the next cycle. A find word
// launches the lookup token into the oldest cell, and the token visits k cells (1 to
// SLOTS) until it hits or reaches the newest entry; its result is then registered.
// A find on an empty ring answers without a walk. Reset clears the pointers, the byte
// count and the token; slot contents are left undefined until written. While a
// result waits under out_stall_i, or a find token is still walking, in_stall_o is high.

module ring_entry_store_offset_lookup_core #(
  parameter int SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [resol_pkg::HANDLE_W-1:0]      entry_handle_i,
  input  logic [resol_pkg::LENGTH_W-1:0]      entry_length_i,
  input  logic [resol_pkg::OFFSET_W-1:0]      byte_offset_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [resol_pkg::SLOT_OUT_W-1:0]    slot_index_o,
  output logic [resol_pkg::HANDLE_W-1:0]      hit_handle_o,
  output logic [resol_pkg::LENGTH_W-1:0]      offset_in_entry_o,
  output logic                                evicted_o,
  output logic [resol_pkg::HANDLE_W-1:0]      evicted_handle_o,
  output logic [resol_pkg::TOTAL_W-1:0]       total_bytes_o
);

  localparam int IDX_W = $clog2(SLOTS);
  // The running byte count is wide enough for every slot at full length.
  localparam int SUM_W = $clog2(SLOTS * 65535 + 1);
  localparam int BIG_W = (SUM_W > resol_pkg::TOTAL_W) ? SUM_W : resol_pkg::TOTAL_W;
  localparam int EXT_W = (IDX_W > resol_pkg::SLOT_OUT_W) ? IDX_W : resol_pkg::SLOT_OUT_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                   state_q;
  logic [IDX_W-1:0]         write_q, oldest_q;
  logic                     full_q;
  logic [SUM_W-1:0]         bytes_q;

  logic                     out_valid_q, out_valid_d, found_q, evicted_q;
  logic [resol_pkg::SLOT_OUT_W-1:0] slot_q;
  logic [resol_pkg::HANDLE_W-1:0]   hit_handle_q, evicted_handle_q;
  logic [resol_pkg::LENGTH_W-1:0]   off_q;
  logic [resol_pkg::TOTAL_W-1:0]    total_q;

  // Cell row signals.
  resol_pkg::tok_t                  cell_tok   [SLOTS];
  resol_pkg::res_t                  cell_res   [SLOTS];
  logic [IDX_W-1:0]                 cell_slot  [SLOTS];
  logic [resol_pkg::HANDLE_W-1:0]   cell_handle[SLOTS];
  logic [resol_pkg::LENGTH_W-1:0]   cell_length[SLOTS];
  logic [SLOTS-1:0]                 cell_we, cell_launch;

  logic                     accept, do_add, do_find, empty;
  logic [IDX_W-1:0]         write_next, oldest_next;
  logic [SUM_W-1:0]         bytes_add;
  logic [resol_pkg::TOTAL_W-1:0] total_now, total_add;
  resol_pkg::res_t          res_any;
  logic [IDX_W-1:0]         slot_any;
  logic [EXT_W-1:0]         slot_ext;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(SLOTS - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  function automatic logic [resol_pkg::TOTAL_W-1:0] saturate(input logic [SUM_W-1:0] v);
    logic [BIG_W-1:0] wide;
    wide = BIG_W'(v);
    return (wide > BIG_W'(resol_pkg::TOTAL_MAX)) ? resol_pkg::TOTAL_MAX
                                                 : wide[resol_pkg::TOTAL_W-1:0];
  endfunction

  // A new word is refused while a token walks or while a result is held by the sink.
  assign in_stall_o = (state_q == ST_WALK) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign do_add     = accept && (kind_i == resol_pkg::KIND_ADD);
  assign do_find    = accept && (kind_i == resol_pkg::KIND_FIND);
  assign empty      = (write_q == oldest_q) && !full_q;

  // An add on a full ring drops the oldest entry's bytes before adding the new ones.
  assign bytes_add   = bytes_q
                     - (full_q ? SUM_W'(cell_length[write_q]) : '0)
                     + SUM_W'(entry_length_i);
  assign write_next  = next_slot(write_q);
  assign oldest_next = full_q ? next_slot(oldest_q) : oldest_q;
  assign total_now   = saturate(bytes_q);
  assign total_add   = saturate(bytes_add);

  // Cell i receives the token from cell i-1, closing the row into a ring.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? SLOTS - 1 : i - 1;

    assign cell_we[i]     = do_add && (write_q == IDX_W'(i));
    assign cell_launch[i] = do_find && !empty && (oldest_q == IDX_W'(i));

    resol_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .we_i         (cell_we[i]),
      .handle_i     (entry_handle_i),
      .length_i     (entry_length_i),
      .write_slot_i (write_q),
      .launch_i     (cell_launch[i]),
      .offset_i     (byte_offset_i),
      .tok_i        (cell_tok[PREV]),
      .tok_o        (cell_tok[i]),
      .res_o        (cell_res[i]),
      .slot_o       (cell_slot[i]),
      .handle_o     (cell_handle[i]),
      .length_o     (cell_length[i])
    );
  end

  // Only the cell holding the token drives a nonzero answer, so an OR collects it.
  always_comb begin
    res_any  = '0;
    slot_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      res_any  = res_any | cell_res[i];
      slot_any = slot_any | cell_slot[i];
    end
  end

  assign slot_ext = EXT_W'(slot_any);

  // The output word stays while the sink stalls it, and a finished add, an empty-ring
  // find or the end of a walk loads a new one.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (do_add || (do_find && empty)) begin
      out_valid_d = 1'b1;
    end
    if ((state_q == ST_WALK) && (res_any.hit || res_any.miss)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      write_q          <= '0;
      oldest_q         <= '0;
      full_q           <= 1'b0;
      bytes_q          <= '0;
      out_valid_q      <= 1'b0;
      found_q          <= 1'b0;
      slot_q           <= '0;
      hit_handle_q     <= '0;
      off_q            <= '0;
      evicted_q        <= 1'b0;
      evicted_handle_q <= '0;
      total_q          <= '0;
    end else begin
      out_valid_q <= out_valid_d;

      case (state_q)
        ST_IDLE: begin
          if (do_add) begin
            write_q          <= write_next;
            oldest_q         <= oldest_next;
            full_q           <= full_q || (write_next == oldest_next);
            bytes_q          <= bytes_add;
            found_q          <= 1'b0;
            slot_q           <= '0;
            hit_handle_q     <= '0;
            off_q            <= '0;
            evicted_q        <= full_q;
            evicted_handle_q <= full_q ? cell_handle[write_q] : '0;
            total_q          <= total_add;
          end else if (do_find) begin
            if (empty) begin
              found_q          <= 1'b0;
              slot_q           <= '0;
              hit_handle_q     <= '0;
              off_q            <= '0;
              evicted_q        <= 1'b0;
              evicted_handle_q <= '0;
              total_q          <= total_now;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (res_any.hit || res_any.miss) begin
            state_q          <= ST_IDLE;
            found_q          <= res_any.hit;
            slot_q           <= slot_ext[resol_pkg::SLOT_OUT_W-1:0];
            hit_handle_q     <= res_any.handle;
            off_q            <= res_any.off;
            evicted_q        <= 1'b0;
            evicted_handle_q <= '0;
            total_q          <= total_now;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign slot_index_o      = slot_q;
  assign hit_handle_o      = hit_handle_q;
  assign offset_in_entry_o = off_q;
  assign evicted_o         = evicted_q;
  assign evicted_handle_o  = evicted_handle_q;
  assign total_bytes_o     = total_q;

endmodule

>>> design/resol_cell.sv
module resol_cell #(
  parameter int SLOTS = 16,
  parameter int IDX = 0,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [resol_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [resol_pkg::LENGTH_W-1:0]   length_i,
  input  logic [IDX_W-1:0]                 write_slot_i,
  input  logic                             launch_i,
  input  logic [resol_pkg::OFFSET_W-1:0]   offset_i,
  input  resol_pkg::tok_t                  tok_i,
  output resol_pkg::tok_t                  tok_o,
  output resol_pkg::res_t                  res_o,
  output logic [IDX_W-1:0]                 slot_o,
  output logic [resol_pkg::HANDLE_W-1:0]   handle_o,
  output logic [resol_pkg::LENGTH_W-1:0]   length_o
);

  localparam int NEXT = (IDX + 1 >= SLOTS) ? 0 : IDX + 1;
  localparam int PAD_W = resol_pkg::OFFSET_W - resol_pkg::LENGTH_W;

  logic [resol_pkg::HANDLE_W-1:0] handle_q;
  logic [resol_pkg::LENGTH_W-1:0] length_q;
  resol_pkg::tok_t                tok_q, tok_d;
  logic [resol_pkg::OFFSET_W-1:0] len_ext;
  logic                           hit, last;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      handle_q <= handle_i;
      length_q <= length_i;
    end
  end

  always_comb begin
    if (launch_i) begin
      tok_d.active = 1'b1;
      tok_d.rem    = offset_i;
    end else begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // A zero-length entry never hits, so the token simply moves past it.
  assign len_ext = {{PAD_W{1'b0}}, length_q};
  assign hit     = tok_q.active && (tok_q.rem < len_ext);
  assign last    = (write_slot_i == IDX_W'(NEXT));

  assign tok_o.active = tok_q.active && !hit && !last;
  assign tok_o.rem    = tok_q.rem - len_ext;

  assign res_o.hit    = hit;
  assign res_o.miss   = tok_q.active && !hit && last;
  assign res_o.handle = hit ? handle_q : '0;
  assign res_o.off    = hit ? tok_q.rem[resol_pkg::LENGTH_W-1:0] : '0;
  assign slot_o       = hit ? IDX_W'(IDX) : '0;

  assign handle_o = handle_q;
  assign length_o = length_q;

endmodule

>>> design/resol_checker.sv
`include "ring_entry_store_offset_lookup_core_macros.svh"

module resol_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                kind_i,
  input logic [resol_pkg::HANDLE_W-1:0]      entry_handle_i,
  input logic [resol_pkg::LENGTH_W-1:0]      entry_length_i,
  input logic [resol_pkg::OFFSET_W-1:0]      byte_offset_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                found_o,
  input logic [resol_pkg::SLOT_OUT_W-1:0]    slot_index_o,
  input logic [resol_pkg::HANDLE_W-1:0]      hit_handle_o,
  input logic [resol_pkg::LENGTH_W-1:0]      offset_in_entry_o,
  input logic                                evicted_o,
  input logic [resol_pkg::HANDLE_W-1:0]      evicted_handle_o,
  input logic [resol_pkg::TOTAL_W-1:0]       total_bytes_o
);

  // A miss carries no slot, handle or position.
  `RESOL_ASSERT_SAME(a_miss_zero, out_valid_o && !found_o,
    slot_index_o == '0 && hit_handle_o == '0 && offset_in_entry_o == '0)

  // A word is an add or a find, never both kinds of answer.
  `RESOL_ASSERT_SAME(a_one_kind, out_valid_o && evicted_o, !found_o)

  // Without an eviction the evicted handle reads zero.
  `RESOL_ASSERT_SAME(a_no_evict_zero, out_valid_o && !evicted_o, evicted_handle_o == '0)

  // A held result is not overtaken by a new input word.
  `RESOL_ASSERT_SAME(a_no_take_while_held, in_valid_i && !in_stall_o,
    !(out_valid_o && out_stall_i))

  // A stalled result stays presented.
  `RESOL_ASSERT_NEXT(a_out_holds, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind ring_entry_store_offset_lookup_core resol_checker u_resol_checker (.*);

>>> test/ring_entry_store_offset_lookup_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the overwriting ring of entry slots with byte-offset lookup.
// Add words store a handle and a length in the ring. Once the ring is full, each
// add overwrites the oldest slot. Find words locate a byte offset in the
// concatenation of all stored entries, oldest first. A shadow copy of the ring
// predicts every result word when its input word is accepted. The checker process
// compares each accepted result word with the oldest prediction, field by field.
module ring_entry_store_offset_lookup_core_tb;

  localparam int SLOTS            = 16;
  localparam int LONG_HOLD_CYCLES = 80;
  // A find walks at most SLOTS cells, so this covers any word still in flight.
  localparam int SETTLE_CYCLES    = SLOTS + 4;

  // One result word, laid out as the output ports are.
  typedef struct packed {
    logic                             found;
    logic [resol_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [resol_pkg::HANDLE_W-1:0]   hit_handle;
    logic [resol_pkg::LENGTH_W-1:0]   offset_in_entry;
    logic                             evicted;
    logic [resol_pkg::HANDLE_W-1:0]   evicted_handle;
    logic [resol_pkg::TOTAL_W-1:0]    total_bytes;
  } lookup_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             kind_i;
  logic [resol_pkg::HANDLE_W-1:0]   entry_handle_i;
  logic [resol_pkg::LENGTH_W-1:0]   entry_length_i;
  logic [resol_pkg::OFFSET_W-1:0]   byte_offset_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic                             found_o;
  logic [resol_pkg::SLOT_OUT_W-1:0] slot_index_o;
  logic [resol_pkg::HANDLE_W-1:0]   hit_handle_o;
  logic [resol_pkg::LENGTH_W-1:0]   offset_in_entry_o;
  logic                             evicted_o;
  logic [resol_pkg::HANDLE_W-1:0]   evicted_handle_o;
  logic [resol_pkg::TOTAL_W-1:0]    total_bytes_o;

  // Shadow of the ring contents, its pointers and the running byte count.
  logic [resol_pkg::HANDLE_W-1:0] shadow_handles [SLOTS];
  logic [resol_pkg::LENGTH_W-1:0] shadow_lengths [SLOTS];
  int unsigned         shadow_wr_slot = 0;
  int unsigned         shadow_oldest  = 0;
  bit                  shadow_full    = 1'b0;
  int unsigned         shadow_bytes   = 0;

  // Predicted result words, oldest first.
  lookup_result_t expected_results [$];
  lookup_result_t next_expected;
  int             mismatches;

  // Idle controls. The sender and the receiver each insert short random bursts
  // while their flag is set. A long receiver hold is requested through
  // long_hold_req and counted out by the receiver process itself.
  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold_req;

  ring_entry_store_offset_lookup_core #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .entry_handle_i   (entry_handle_i),
    .entry_length_i   (entry_length_i),
    .byte_offset_i    (byte_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .slot_index_o     (slot_index_o),
    .hit_handle_o     (hit_handle_o),
    .offset_in_entry_o(offset_in_entry_o),
    .evicted_o        (evicted_o),
    .evicted_handle_o (evicted_handle_o),
    .total_bytes_o    (total_bytes_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  // Applies one accepted word to the shadow ring and returns the result word
  // that the block must produce for it.
  function automatic lookup_result_t apply_ring_word(
      input logic                           kind,
      input logic [resol_pkg::HANDLE_W-1:0] handle,
      input logic [resol_pkg::LENGTH_W-1:0] length,
      input logic [resol_pkg::OFFSET_W-1:0] offset);
    lookup_result_t r;
    int unsigned    rem;
    int unsigned    idx;
    int             n;
    bit             done;
    r = '0;
    if (kind == resol_pkg::KIND_ADD) begin
      // A full ring loses its oldest entry to the new one, and both pointers move.
      if (shadow_full) begin
        r.evicted        = 1'b1;
        r.evicted_handle = shadow_handles[shadow_wr_slot];
        shadow_bytes     = shadow_bytes - 32'(shadow_lengths[shadow_wr_slot]);
        shadow_oldest    = next_slot(shadow_oldest);
      end
      shadow_handles[shadow_wr_slot] = handle;
      shadow_lengths[shadow_wr_slot] = length;
      shadow_bytes   = shadow_bytes + 32'(length);
      shadow_wr_slot = next_slot(shadow_wr_slot);
      if (shadow_wr_slot == shadow_oldest) shadow_full = 1'b1;
    end else if (shadow_full || shadow_wr_slot != shadow_oldest) begin
      // Walk from the oldest entry. Zero-length entries never match and only
      // pass the remaining offset on unchanged.
      rem  = 32'(offset);
      idx  = shadow_oldest;
      done = 1'b0;
      for (n = 0; n < SLOTS && !done; n++) begin
        if (rem < 32'(shadow_lengths[idx])) begin
          r.found           = 1'b1;
          r.slot_index      = idx[resol_pkg::SLOT_OUT_W-1:0];
          r.hit_handle      = shadow_handles[idx];
          r.offset_in_entry = rem[resol_pkg::LENGTH_W-1:0];
          done              = 1'b1;
        end else begin
          rem = rem - 32'(shadow_lengths[idx]);
          idx = next_slot(idx);
          if (idx == shadow_wr_slot) done = 1'b1;
        end
      end
    end
    r.total_bytes = (shadow_bytes > 32'(resol_pkg::TOTAL_MAX)) ? resol_pkg::TOTAL_MAX
                                                              : shadow_bytes[resol_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  // Offers one word and holds it until the block takes it. The shadow ring is
  // updated at the accepting edge, so the next word sees the current contents.
  task automatic send_word(input logic                           kind,
                           input logic [resol_pkg::HANDLE_W-1:0] handle,
                           input logic [resol_pkg::LENGTH_W-1:0] length,
                           input logic [resol_pkg::OFFSET_W-1:0] offset);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    entry_handle_i <= handle;
    entry_length_i <= length;
    byte_offset_i  <= offset;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(apply_ring_word(kind, handle, length, offset));
  endtask

  // Mostly short entries so that a full ring can still be searched with random
  // offsets, with zero-length and maximum-length entries mixed in.
  function automatic logic [resol_pkg::LENGTH_W-1:0] pick_length();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return resol_pkg::LENGTH_W'($urandom);
      default: return resol_pkg::LENGTH_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Most offsets land inside the stored data. Some sit on the last byte or on
  // the first byte past the data, and some are drawn from the whole field.
  function automatic logic [resol_pkg::OFFSET_W-1:0] pick_offset();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (shadow_bytes == 0 || pick < 2) return resol_pkg::OFFSET_W'($urandom);
    if (pick < 4) return resol_pkg::OFFSET_W'(shadow_bytes);
    if (pick < 6) return resol_pkg::OFFSET_W'(shadow_bytes - 1);
    return resol_pkg::OFFSET_W'($urandom_range(0, shadow_bytes - 1));
  endfunction

  // Fields that the operation ignores still carry random values.
  task automatic send_random_word();
    if ($urandom_range(0, 1) == 0) begin
      send_word(resol_pkg::KIND_ADD, $urandom, pick_length(),
                resol_pkg::OFFSET_W'($urandom));
    end else begin
      send_word(resol_pkg::KIND_FIND, $urandom, resol_pkg::LENGTH_W'($urandom),
                pick_offset());
    end
  endtask

  // Before any add the ring is empty and every find must miss.
  task automatic test_empty_ring_find();
    send_word(resol_pkg::KIND_FIND, '0, '0, '0);
    send_word(resol_pkg::KIND_FIND, '1, '1, '1);
  endtask

  // Extreme handles and lengths, a zero-length entry between two real ones,
  // and finds on both sides of each boundary and far past the data.
  task automatic test_field_extremes();
    send_word(resol_pkg::KIND_ADD, '1, '1, '0);
    send_word(resol_pkg::KIND_ADD, '0, '0, '1);
    send_word(resol_pkg::KIND_ADD, 32'hA5A5_5A5A, 16'd1, '0);
    send_word(resol_pkg::KIND_FIND, '0, '0, 24'd0);
    send_word(resol_pkg::KIND_FIND, '0, '0, 24'd65534);
    // This offset is past the first entry, so the walk must skip the empty
    // entry and hit the one-byte entry after it.
    send_word(resol_pkg::KIND_FIND, '0, '0, 24'd65535);
    send_word(resol_pkg::KIND_FIND, '0, '0, 24'd65536);
    send_word(resol_pkg::KIND_FIND, '0, '0, '1);
  endtask

  // Fill the ring, then add two more so that the maximum entry and the empty
  // entry are evicted in turn. A find on the last byte walks to the last slot with data.
  task automatic test_wrap_eviction();
    int i;
    for (i = 0; i < SLOTS - 1; i++) begin
      send_word(resol_pkg::KIND_ADD, $urandom,
                resol_pkg::LENGTH_W'($urandom_range(0, 300)), '0);
    end
    send_word(resol_pkg::KIND_FIND, '0, '0, resol_pkg::OFFSET_W'(shadow_bytes - 1));
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // block fills and must stall its input until the hold ends.
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (30) send_random_word();
  endtask

  // The sender stops until every outstanding result word has been taken.
  task automatic test_drain_pause();
    repeat (10) send_random_word();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) send_random_word();
  endtask

  task automatic test_random_mix();
    repeat (780) send_random_word();
  endtask

  // The last stretch runs with neither side idling.
  task automatic test_steady_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (150) send_random_word();
  endtask

  // Receiver: random short stall bursts, or one long hold when requested.
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Checker: every accepted result word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word expected none, got total_bytes 0x%0h",
                 $time, total_bytes_o);
      end else begin
        next_expected = expected_results.pop_front();
        check_field("found", 32'(next_expected.found), 32'(found_o));
        check_field("slot_index", 32'(next_expected.slot_index), 32'(slot_index_o));
        check_field("hit_handle", next_expected.hit_handle, hit_handle_o);
        check_field("offset_in_entry", 32'(next_expected.offset_in_entry),
                    32'(offset_in_entry_o));
        check_field("evicted", 32'(next_expected.evicted), 32'(evicted_o));
        check_field("evicted_handle", next_expected.evicted_handle, evicted_handle_o);
        check_field("total_bytes", 32'(next_expected.total_bytes), 32'(total_bytes_o));
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = resol_pkg::KIND_ADD;
    entry_handle_i = '0;
    entry_length_i = '0;
    byte_offset_i  = '0;
    mismatches     = 0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    long_hold_req  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring_find();
    test_field_extremes();
    test_wrap_eviction();
    test_output_backpressure();
    test_drain_pause();
    test_random_mix();
    test_steady_tail();

    // Drain the outstanding result words, then give any stray word time to show.
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/resol_pkg.sv
design/resol_cell.sv
design/ring_entry_store_offset_lookup_core.sv
design/resol_checker.sv
test/ring_entry_store_offset_lookup_core_tb.sv
